// ===== sv/bcd_pkg.sv =====
package bcd_pkg;

   localparam int MaxPoints = 4096;
   localparam int FracBits = 16;
   localparam int AddrW = $clog2(MaxPoints);
   localparam int CountW = AddrW + 1;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;
   localparam int ThrW = 14;
   localparam int CoordW = 16;
   localparam int DistW = 17;
   localparam int BinW = 16;
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_STORE_TPL = 3'd1,
      MODE_STORE_TGT = 3'd2,
      MODE_QUERY_TGT = 3'd3,
      MODE_QUERY_TPL = 3'd4
   } mode_type;

   localparam logic [CsrIdxW-1:0] CSR_COEF_XX = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_COEF_XY = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_X = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COEF_YX = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_COEF_YY = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_Y = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_THRESHOLD = 3'd6;

   // Work item handed from the front end to the back end
   typedef struct packed {
      logic [2:0] mode;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
   } work_type;

endpackage

// ===== sv/bcd_ram.sv =====
module bcd_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bcd_front.sv =====
module bcd_front import bcd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_mode,
   input  logic signed [CoordW-1:0] req_point_x,
   input  logic signed [CoordW-1:0] req_point_y,
   input  logic signed [CsrDataW-1:0] coef_xx,
   input  logic signed [CsrDataW-1:0] coef_xy,
   input  logic signed [CsrDataW-1:0] offset_x,
   input  logic signed [CsrDataW-1:0] coef_yx,
   input  logic signed [CsrDataW-1:0] coef_yy,
   input  logic signed [CsrDataW-1:0] offset_y,
   output logic q_valid,
   input  logic q_pop,
   output work_type q_data
);

   localparam int ProdW = 2 * CsrDataW;
   localparam int AccW = ProdW + 2;
   localparam logic [AccW-1:0] Half = AccW'(1) << (FracBits - 1);
   localparam int PtrW = $clog2(QueueDepth);

   // Stage 1: capture item, stage 2: products, stage 3: sum; rounding is combinational
   logic s1_valid_ff, s1_valid_in;
   work_type s1_ff;
   logic s2_valid_ff;
   work_type s2_ff;
   logic signed [ProdW-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic s3_valid_ff;
   work_type s3_ff;
   logic signed [AccW-1:0] accx_ff, accy_ff;
   logic map3_ff, map2_ff, map1_ff;

   logic busy;
   logic req_take;
   work_type fin;

   // Queue storage
   work_type q_mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0] q_cnt_ff;
   logic q_push;

   function automatic logic signed [CoordW-1:0] round_sat(input logic signed [AccW-1:0] a);
      logic [AccW-1:0] mag;
      logic [AccW-1:0] r;
      logic signed [AccW:0] v;
      begin
         mag = a[AccW-1] ? AccW'(-a) : AccW'(a);
         r = (mag + Half) >> FracBits;
         v = a[AccW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
         if (v > 32767) begin
            round_sat = 16'sd32767;
         end else if (v < -32768) begin
            round_sat = -16'sd32768;
         end else begin
            round_sat = v[CoordW-1:0];
         end
      end
   endfunction

   // One item in the pipe at a time; accept only with a queue slot free
   assign busy = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign req_stall = busy | (q_cnt_ff == (PtrW+1)'(QueueDepth));
   assign req_take = req_valid & ~req_stall;
   assign s1_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Advance payload through multiply, sum and round
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= '{mode: req_mode, x: req_point_x, y: req_point_y};
         map1_ff <= (req_mode == MODE_STORE_TPL) || (req_mode == MODE_QUERY_TPL);
      end
      s2_ff <= s1_ff;
      map2_ff <= map1_ff;
      pxx_ff <= ProdW'(s1_ff.x) * coef_xx;
      pxy_ff <= ProdW'(s1_ff.y) * coef_xy;
      pyx_ff <= ProdW'(s1_ff.x) * coef_yx;
      pyy_ff <= ProdW'(s1_ff.y) * coef_yy;
      s3_ff <= s2_ff;
      map3_ff <= map2_ff;
      accx_ff <= AccW'(pxx_ff) + AccW'(pxy_ff) + AccW'(offset_x);
      accy_ff <= AccW'(pyx_ff) + AccW'(pyy_ff) + AccW'(offset_y);
   end

   always_comb begin
      fin = s3_ff;
      if (map3_ff) begin
         fin.x = round_sat(accx_ff);
         fin.y = round_sat(accy_ff);
      end
   end

   // Queue between front and back
   assign q_push = s3_valid_ff;
   assign q_valid = (q_cnt_ff != '0);
   assign q_data = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[wr_ptr_ff] <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + (PtrW+1)'(q_push) - (PtrW+1)'(q_pop);
      end
   end

endmodule

// ===== sv/bcd_back.sv =====
module bcd_back import bcd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  work_type q_data,
   input  logic [ThrW-1:0] threshold,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_status,
   output logic signed [CoordW-1:0] rsp_out_x,
   output logic signed [CoordW-1:0] rsp_out_y,
   output logic [DistW-1:0] rsp_distance,
   output logic rsp_defect
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIVQ = 7'b0000010,
      ST_SCAN = 7'b0000100,
      ST_DIVS = 7'b0001000,
      ST_CMP = 7'b0010000,
      ST_DONE = 7'b0100000,
      ST_OUT = 7'b1000000
   } state_type;

   localparam int DivW = CoordW;
   localparam logic signed [BinW-1:0] BinOne = BinW'(1);

   state_type state_ff;
   work_type item_ff;
   logic [CountW-1:0] tpl_cnt_ff, tgt_cnt_ff;
   logic [CountW-1:0] idx_ff;
   logic [ThrW:0] thr_ff;
   logic [ThrW+1:0] bin_ff;
   logic signed [BinW-1:0] qbx_ff, qby_ff;
   logic kx_ff, ky_ff;
   logic found_ff;
   logic [DistW-1:0] best_ff;
   logic signed [CoordW-1:0] sx_ff, sy_ff;

   // Shared restoring divider for x and y magnitudes
   logic [DivW-1:0] nx_ff, ny_ff;
   logic [DivW-1:0] qx_ff, qy_ff;
   logic [ThrW+2:0] rx_ff, ry_ff;
   logic [$clog2(DivW+1)-1:0] dstep_ff;
   logic [ThrW+2:0] rx_sh, ry_sh;
   logic signed [BinW-1:0] bx_res, by_res;
   logic signed [ThrW+2:0] remx_s, remy_s;

   // Output register
   logic out_valid_ff;
   logic out_status_ff, out_defect_ff;
   logic signed [CoordW-1:0] out_x_ff, out_y_ff;
   logic [DistW-1:0] out_dist_ff;

   // Memories
   logic tpl_we, tgt_we;
   logic [AddrW-1:0] mem_addr;
   logic [2*CoordW-1:0] tpl_rd, tgt_rd, rd_word;
   logic is_tplq;

   logic [DistW-1:0] dcur;
   logic signed [CoordW:0] ddx, ddy;
   logic hit;

   assign is_tplq = (item_ff.mode == MODE_QUERY_TGT);
   assign mem_addr = idx_ff[AddrW-1:0];
   assign tpl_we = (state_ff == ST_IDLE) && q_valid && (q_data.mode == MODE_STORE_TPL)
      && (tpl_cnt_ff < CountW'(MaxPoints)) && ~out_valid_ff;
   assign tgt_we = (state_ff == ST_IDLE) && q_valid && (q_data.mode == MODE_STORE_TGT)
      && (tgt_cnt_ff < CountW'(MaxPoints)) && ~out_valid_ff;

   bcd_ram #(.Width(2*CoordW), .Depth(MaxPoints)) u_tpl_ram (
      .clock(clock), .wr_en(tpl_we), .wr_addr(tpl_cnt_ff[AddrW-1:0]),
      .wr_data({q_data.x, q_data.y}), .rd_addr(mem_addr), .rd_data(tpl_rd)
   );

   bcd_ram #(.Width(2*CoordW), .Depth(MaxPoints)) u_tgt_ram (
      .clock(clock), .wr_en(tgt_we), .wr_addr(tgt_cnt_ff[AddrW-1:0]),
      .wr_data({q_data.x, q_data.y}), .rd_addr(mem_addr), .rd_data(tgt_rd)
   );

   assign rd_word = is_tplq ? tpl_rd : tgt_rd;

   // Divider step and signed results
   assign rx_sh = {rx_ff[ThrW+1:0], nx_ff[DivW-1]};
   assign ry_sh = {ry_ff[ThrW+1:0], ny_ff[DivW-1]};

   function automatic logic [DivW-1:0] mag16(input logic signed [CoordW-1:0] v);
      mag16 = v[CoordW-1] ? DivW'(-v) : DivW'(v);
   endfunction

   always_comb begin
      if (item_ff.mode == MODE_QUERY_TGT || item_ff.mode == MODE_QUERY_TPL) begin
         bx_res = (state_ff == ST_DIVQ ? item_ff.x[CoordW-1] : sx_ff[CoordW-1])
            ? -$signed(qx_ff) : $signed(qx_ff);
         by_res = (state_ff == ST_DIVQ ? item_ff.y[CoordW-1] : sy_ff[CoordW-1])
            ? -$signed(qy_ff) : $signed(qy_ff);
      end else begin
         bx_res = '0;
         by_res = '0;
      end
      remx_s = item_ff.x[CoordW-1] ? -$signed(rx_ff) : $signed(rx_ff);
      remy_s = item_ff.y[CoordW-1] ? -$signed(ry_ff) : $signed(ry_ff);
   end

   // Candidate distance
   always_comb begin
      ddx = $signed({sx_ff[CoordW-1], sx_ff}) - $signed({item_ff.x[CoordW-1], item_ff.x});
      ddy = $signed({sy_ff[CoordW-1], sy_ff}) - $signed({item_ff.y[CoordW-1], item_ff.y});
      dcur = DistW'(ddx[CoordW] ? -ddx : ddx) + DistW'(ddy[CoordW] ? -ddy : ddy);
      hit = ((bx_res == qbx_ff) || (bx_res == (kx_ff ? qbx_ff + BinOne : qbx_ff - BinOne)))
         && ((by_res == qby_ff) || (by_res == (ky_ff ? qby_ff + BinOne : qby_ff - BinOne)));
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid && ~out_valid_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tpl_cnt_ff <= '0;
         tgt_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && ~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff) inside
            ST_IDLE: begin
               if (q_pop) begin
                  item_ff <= q_data;
                  out_x_ff <= q_data.x;
                  out_y_ff <= q_data.y;
                  out_status_ff <= 1'b0;
                  out_dist_ff <= '0;
                  out_defect_ff <= 1'b0;
                  thr_ff <= (threshold == '0) ? (ThrW+1)'(1) : (ThrW+1)'(threshold);
                  bin_ff <= (threshold == '0) ? (ThrW+2)'(2) : {1'b0, threshold, 1'b0};
                  case (q_data.mode) inside
                     MODE_CLEAR: begin
                        tpl_cnt_ff <= '0;
                        tgt_cnt_ff <= '0;
                        out_x_ff <= '0;
                        out_y_ff <= '0;
                        out_valid_ff <= 1'b1;
                     end
                     MODE_STORE_TPL: begin
                        if (tpl_we) begin
                           tpl_cnt_ff <= tpl_cnt_ff + 1'b1;
                        end else begin
                           out_status_ff <= 1'b1;
                        end
                        out_valid_ff <= 1'b1;
                     end
                     MODE_STORE_TGT: begin
                        if (tgt_we) begin
                           tgt_cnt_ff <= tgt_cnt_ff + 1'b1;
                        end else begin
                           out_status_ff <= 1'b1;
                        end
                        out_valid_ff <= 1'b1;
                     end
                     MODE_QUERY_TGT, MODE_QUERY_TPL: begin
                        nx_ff <= mag16(q_data.x);
                        ny_ff <= mag16(q_data.y);
                        rx_ff <= '0;
                        ry_ff <= '0;
                        dstep_ff <= '0;
                        found_ff <= 1'b0;
                        best_ff <= '0;
                        idx_ff <= '0;
                        state_ff <= ST_DIVQ;
                     end
                     default: begin
                        out_x_ff <= '0;
                        out_y_ff <= '0;
                        out_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_DIVQ, ST_DIVS: begin
               if (dstep_ff == ($clog2(DivW+1))'(DivW)) begin
                  if (state_ff == ST_DIVQ) begin
                     qbx_ff <= bx_res;
                     qby_ff <= by_res;
                     kx_ff <= (remx_s >= $signed({2'b0, thr_ff}));
                     ky_ff <= (remy_s >= $signed({2'b0, thr_ff}));
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_CMP;
                  end
               end else begin
                  dstep_ff <= dstep_ff + 1'b1;
                  nx_ff <= {nx_ff[DivW-2:0], 1'b0};
                  ny_ff <= {ny_ff[DivW-2:0], 1'b0};
                  if (rx_sh >= {1'b0, bin_ff}) begin
                     rx_ff <= rx_sh - {1'b0, bin_ff};
                     qx_ff <= {qx_ff[DivW-2:0], 1'b1};
                  end else begin
                     rx_ff <= rx_sh;
                     qx_ff <= {qx_ff[DivW-2:0], 1'b0};
                  end
                  if (ry_sh >= {1'b0, bin_ff}) begin
                     ry_ff <= ry_sh - {1'b0, bin_ff};
                     qy_ff <= {qy_ff[DivW-2:0], 1'b1};
                  end else begin
                     ry_ff <= ry_sh;
                     qy_ff <= {qy_ff[DivW-2:0], 1'b0};
                  end
               end
            end
            ST_SCAN: begin
               // Memory read at idx_ff is issued here; its registered word is used in ST_CMP
               if (idx_ff >= (is_tplq ? tpl_cnt_ff : tgt_cnt_ff)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_CMP;
                  dstep_ff <= '1;
               end
            end
            ST_CMP: begin
               if (dstep_ff == '1) begin
                  // Stored point available: start dividing it
                  sx_ff <= rd_word[2*CoordW-1:CoordW];
                  sy_ff <= rd_word[CoordW-1:0];
                  nx_ff <= mag16(rd_word[2*CoordW-1:CoordW]);
                  ny_ff <= mag16(rd_word[CoordW-1:0]);
                  rx_ff <= '0;
                  ry_ff <= '0;
                  dstep_ff <= '0;
                  state_ff <= ST_DIVS;
               end else begin
                  if (hit && (!found_ff || dcur < best_ff)) begin
                     best_ff <= dcur;
                     found_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_DONE: begin
               out_dist_ff <= found_ff ? best_ff : DistW'(thr_ff) + 1'b1;
               out_defect_ff <= found_ff ? (best_ff > DistW'(thr_ff)) : 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!out_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_defect = out_defect_ff;

endmodule

// ===== sv/binned_contour_distance_check.sv =====
// Clear, store and unused modes answer straight from idle; a query scans every
// point of the opposite store: the shared bin divider handles the query point
// first and then each stored point scanned.
// The front end holds one item in its pipe at a time and takes a new request only
// with a queue slot free; the back end holds one item at a time.
// Reset is synchronous, active high, clears both counts and restores register defaults.
module binned_contour_distance_check import bcd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_mode,
   input  logic signed [CoordW-1:0] req_point_x,
   input  logic signed [CoordW-1:0] req_point_y,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_status,
   output logic signed [CoordW-1:0] rsp_out_x,
   output logic signed [CoordW-1:0] rsp_out_y,
   output logic [DistW-1:0] rsp_distance,
   output logic rsp_defect,
   input  logic csr_write,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   logic signed [CsrDataW-1:0] coef_xx_ff, coef_xy_ff, offset_x_ff;
   logic signed [CsrDataW-1:0] coef_yx_ff, coef_yy_ff, offset_y_ff;
   logic [ThrW-1:0] thr_ff;
   logic q_valid, q_pop;
   work_type q_data;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= 32'sd65536;
         coef_xy_ff <= '0;
         offset_x_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= 32'sd65536;
         offset_y_ff <= '0;
         thr_ff <= ThrW'(5);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COEF_XX: coef_xx_ff <= csr_data;
            CSR_COEF_XY: coef_xy_ff <= csr_data;
            CSR_OFFSET_X: offset_x_ff <= csr_data;
            CSR_COEF_YX: coef_yx_ff <= csr_data;
            CSR_COEF_YY: coef_yy_ff <= csr_data;
            CSR_OFFSET_Y: offset_y_ff <= csr_data;
            CSR_THRESHOLD: thr_ff <= csr_data[ThrW-1:0];
            default: ;
         endcase
      end
   end

   bcd_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .coef_xx(coef_xx_ff), .coef_xy(coef_xy_ff), .offset_x(offset_x_ff),
      .coef_yx(coef_yx_ff), .coef_yy(coef_yy_ff), .offset_y(offset_y_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   bcd_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data), .threshold(thr_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_distance(rsp_distance), .rsp_defect(rsp_defect)
   );

endmodule

// ===== tb/bcd_distance_monitor.sv =====
module bcd_distance_monitor import bcd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [2:0] req_mode,
   input  logic signed [CoordW-1:0] req_point_x,
   input  logic signed [CoordW-1:0] req_point_y,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic rsp_status,
   input  logic signed [CoordW-1:0] rsp_out_x,
   input  logic signed [CoordW-1:0] rsp_out_y,
   input  logic [DistW-1:0] rsp_distance,
   input  logic rsp_defect,
   input  logic csr_write,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output int error_count,
   output int awaited
);

   typedef struct {
      logic status;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic [DistW-1:0] distance;
      logic defect;
   } outcome_type;

   outcome_type expected_results[$];

   // Mirror of the register file and both point stores
   longint mat_xx, mat_xy, shift_x, mat_yx, mat_yy, shift_y;
   logic [ThrW-1:0] threshold;
   int tpl_x[MaxPoints], tpl_y[MaxPoints], tgt_x[MaxPoints], tgt_y[MaxPoints];
   int tpl_count, tgt_count;

   // Round half away from zero, then saturate to the coordinate range
   function automatic int round_sat(input longint acc);
      longint half, r;
      half = longint'(1) <<< (FracBits - 1);
      if (acc >= 0) r = (acc + half) >>> FracBits;
      else r = -((-acc + half) >>> FracBits);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
   endfunction

   // Nearest stored point of the opposite store within the four chosen bins
   function automatic int nearest(input int qx, input int qy, input bit in_tpl, input int t);
      int b, bx, by, k1, k2, n, sx, sy, px, py, dx, dy, d, best;
      bit found;
      b = 2 * t;
      bx = qx / b;
      by = qy / b;
      k1 = (qx % b >= t) ? 1 : -1;
      k2 = (qy % b >= t) ? 1 : -1;
      n = in_tpl ? tpl_count : tgt_count;
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
         px = in_tpl ? tpl_x[i] : tgt_x[i];
         py = in_tpl ? tpl_y[i] : tgt_y[i];
         sx = px / b;
         sy = py / b;
         if ((sx == bx || sx == bx + k1) && (sy == by || sy == by + k2)) begin
            dx = px - qx;
            dy = py - qy;
            d = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
            if (!found || d < best) begin
               best = d;
               found = 1;
            end
         end
      end
      return found ? best : t + 1;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type e, got;
      int t, px, py, mx, my;
      if (reset) begin
         mat_xx = 65536; mat_xy = 0; shift_x = 0;
         mat_yx = 0; mat_yy = 65536; shift_y = 0;
         threshold = ThrW'(5);
         tpl_count = 0;
         tgt_count = 0;
         expected_results.delete();
         error_count = 0;
      end else begin
         // Track register writes
         if (csr_write) begin
            case (csr_index)
               CSR_COEF_XX: mat_xx = longint'($signed(csr_data));
               CSR_COEF_XY: mat_xy = longint'($signed(csr_data));
               CSR_OFFSET_X: shift_x = longint'($signed(csr_data));
               CSR_COEF_YX: mat_yx = longint'($signed(csr_data));
               CSR_COEF_YY: mat_yy = longint'($signed(csr_data));
               CSR_OFFSET_Y: shift_y = longint'($signed(csr_data));
               CSR_THRESHOLD: threshold = csr_data[ThrW-1:0];
               default: ;
            endcase
         end

         // Predict the outcome of an accepted request beat
         if (req_valid && !req_stall) begin
            t = (threshold == 0) ? 1 : int'(threshold);
            px = int'(req_point_x);
            py = int'(req_point_y);
            mx = round_sat(longint'(px) * mat_xx + longint'(py) * mat_xy + shift_x);
            my = round_sat(longint'(px) * mat_yx + longint'(py) * mat_yy + shift_y);
            e = '{status: 0, x: 0, y: 0, distance: 0, defect: 0};
            case (mode_type'(req_mode))
               MODE_CLEAR: begin
                  tpl_count = 0;
                  tgt_count = 0;
               end
               MODE_STORE_TPL: begin
                  e.x = CoordW'(mx);
                  e.y = CoordW'(my);
                  if (tpl_count >= MaxPoints) e.status = 1;
                  else begin
                     tpl_x[tpl_count] = mx;
                     tpl_y[tpl_count] = my;
                     tpl_count++;
                  end
               end
               MODE_STORE_TGT: begin
                  e.x = CoordW'(px);
                  e.y = CoordW'(py);
                  if (tgt_count >= MaxPoints) e.status = 1;
                  else begin
                     tgt_x[tgt_count] = px;
                     tgt_y[tgt_count] = py;
                     tgt_count++;
                  end
               end
               MODE_QUERY_TGT: begin
                  e.x = CoordW'(px);
                  e.y = CoordW'(py);
                  e.distance = DistW'(nearest(px, py, 1, t));
                  e.defect = e.distance > t;
               end
               MODE_QUERY_TPL: begin
                  e.x = CoordW'(mx);
                  e.y = CoordW'(my);
                  e.distance = DistW'(nearest(mx, my, 0, t));
                  e.defect = e.distance > t;
               end
               default: ;
            endcase
            expected_results = {expected_results, e};
         end

         // Compare an accepted result beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               got = expected_results.pop_front();
               if (rsp_status !== got.status) begin
                  $error("status expected %0d got %0d", got.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_x !== got.x) begin
                  $error("out_x expected %0d got %0d", got.x, rsp_out_x);
                  error_count++;
               end
               if (rsp_out_y !== got.y) begin
                  $error("out_y expected %0d got %0d", got.y, rsp_out_y);
                  error_count++;
               end
               if (rsp_distance !== got.distance) begin
                  $error("distance expected %0d got %0d", got.distance, rsp_distance);
                  error_count++;
               end
               if (rsp_defect !== got.defect) begin
                  $error("defect expected %0d got %0d", got.defect, rsp_defect);
                  error_count++;
               end
            end
         end
      end
      awaited = expected_results.size();
   end

endmodule

// ===== tb/binned_contour_distance_check_test.sv =====
module binned_contour_distance_check_test;
   import bcd_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_mode = MODE_CLEAR;
   logic signed [CoordW-1:0] req_point_x = 0;
   logic signed [CoordW-1:0] req_point_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_status;
   logic signed [CoordW-1:0] rsp_out_x, rsp_out_y;
   logic [DistW-1:0] rsp_distance;
   logic rsp_defect;
   logic csr_write = 0;
   logic [CsrIdxW-1:0] csr_index = CSR_COEF_XX;
   logic [CsrDataW-1:0] csr_data = 0;

   int error_count, awaited;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_go = 0;
   int thr = 5;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   binned_contour_distance_check uut (.*);
   bcd_distance_monitor monitor (.*);

   // Receiver: random stall, or one long counted hold-off once requested
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_go && hold_left < 300) begin
         rsp_stall <= 1;
         hold_left <= hold_left + 1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send(input logic [2:0] m, input int x, input int y);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= m;
      req_point_x <= x[CoordW-1:0];
      req_point_y <= y[CoordW-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every result is back, then let the block settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic set_map(input int xx, input int xy, input int ox, input int yx,
                          input int yy, input int oy, input int t);
      set_reg(CSR_COEF_XX, xx);
      set_reg(CSR_COEF_XY, xy);
      set_reg(CSR_OFFSET_X, ox);
      set_reg(CSR_COEF_YX, yx);
      set_reg(CSR_COEF_YY, yy);
      set_reg(CSR_OFFSET_Y, oy);
      set_reg(CSR_THRESHOLD, t);
      csr_write <= 0;
      @(posedge clock);
      thr = (t == 0) ? 1 : t;
   endtask

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Pick a random register setting, extremes included
   task automatic random_config();
      int t, sel;
      case ($urandom_range(4))
         0: t = 0;
         1: t = 1;
         2: t = 16383;
         default: t = $urandom_range(40, 2);
      endcase
      sel = $urandom_range(5);
      case (sel)
         0: set_map(65536, 0, 0, 0, 65536, 0, t);
         1: set_map(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000, t);
         2: set_map(32768, 32768, 32768, -32768, 32768, -32768, t);
         3: set_map($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), t);
         default: set_map(65536 + $urandom_range(8192) - 4096, $urandom_range(8192) - 4096,
                          ($urandom_range(200) - 100) * 65536 + $urandom_range(65535),
                          $urandom_range(8192) - 4096, 65536 + $urandom_range(8192) - 4096,
                          ($urandom_range(200) - 100) * 65536 + $urandom_range(65535), t);
      endcase
   endtask

   // One scene: clear, then mostly stores and queries around one spot
   task automatic scene(input int beats);
      int cx, cy, r, spread;
      send(MODE_CLEAR, $urandom(), $urandom());
      spread = (thr > 2000) ? 6000 : 3 * thr + 2;
      cx = $urandom_range(60000) - 30000;
      cy = $urandom_range(60000) - 30000;
      repeat (beats) begin
         r = $urandom_range(99);
         if (r < 35)
            send(MODE_STORE_TGT, clamp16(cx + $urandom_range(2 * spread) - spread),
                 clamp16(cy + $urandom_range(2 * spread) - spread));
         else if (r < 55)
            send(MODE_STORE_TPL, clamp16(cx + $urandom_range(2 * spread) - spread),
                 clamp16(cy + $urandom_range(2 * spread) - spread));
         else if (r < 70)
            send(MODE_QUERY_TGT, clamp16(cx + $urandom_range(2 * spread) - spread),
                 clamp16(cy + $urandom_range(2 * spread) - spread));
         else if (r < 85)
            send(MODE_QUERY_TPL, clamp16(cx + $urandom_range(2 * spread) - spread),
                 clamp16(cy + $urandom_range(2 * spread) - spread));
         else if (r < 92)
            send(3'($urandom_range(4)), $urandom(), $urandom());
         else
            send(3'($urandom_range(7, 5)), $urandom(), $urandom());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset map, corners, negative remainders, unused modes
      send(MODE_QUERY_TPL, 0, 0);
      send(MODE_STORE_TGT, 0, 0);
      send(MODE_STORE_TGT, -7, -3);
      send(MODE_QUERY_TPL, 1, 2);
      send(MODE_QUERY_TPL, -4, -9);
      send(MODE_STORE_TPL, -32768, 32767);
      send(MODE_STORE_TGT, 32767, -32768);
      send(MODE_QUERY_TGT, -32768, 32767);
      send(MODE_QUERY_TPL, 32767, -32768);
      send(MODE_QUERY_TGT, 32767, 32767);
      send(3'd5, -1, -1);
      send(3'd6, 21845, -21846);
      send(3'd7, -1, 0);
      send(MODE_CLEAR, -1, -1);
      send(MODE_QUERY_TGT, 3, 3);
      drain();
      // Half scale map for rounding ties, zero threshold
      set_map(32768, 0, 32768, 0, -32768, -32768, 0);
      send(MODE_STORE_TPL, 1, 1);
      send(MODE_STORE_TPL, -1, -3);
      send(MODE_QUERY_TPL, 3, -3);
      send(MODE_QUERY_TGT, 5, 5);
      drain();
      // Saturating map, widest threshold
      set_map(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 16383);
      send(MODE_STORE_TPL, 100, -100);
      send(MODE_STORE_TGT, 32767, -32768);
      send(MODE_QUERY_TPL, 100, -100);
      send(MODE_QUERY_TGT, 32000, -32000);
      drain();

      // Random phases: no idling, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 47) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 47) : 0;
         repeat (2) begin
            random_config();
            scene(12);
            drain();
         end
      end

      // Long receiver hold-off while the sender keeps offering stores
      gap_pct = 0;
      stall_pct = 0;
      set_map(65536, 0, 0, 0, 65536, 0, 9);
      @(posedge clock);
      hold_go <= 1;
      send(MODE_CLEAR, 0, 0);
      repeat (12) send(MODE_STORE_TGT, $urandom_range(60) - 30, $urandom_range(60) - 30);
      send(MODE_QUERY_TPL, 0, 0);
      drain();

      if (error_count == 0 && awaited == 0)
         $display("binned_contour_distance_check verification clean");
      else
         $display("binned_contour_distance_check verification failed");
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("binned_contour_distance_check verification failed");
      $finish;
   end

endmodule
